@@ design/accumulator_machine_execute_core_assert.svh @@
// Assertion macros for the accumulator machine execute core.
// Each macro expands to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef ACCUMULATOR_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define AME_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define AME_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define AME_ASSERT(lbl, clk, rst_n, prop)
`define AME_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ design/ame_pkg.sv @@
package ame_pkg;

    // Field widths
    localparam int WORD_W    = 16;
    localparam int ADDR_IN_W = 8;
    localparam int OP_W      = 4;
    localparam int ADDR_SPAN = 2 ** ADDR_IN_W;

    // Default data memory depth in words
    localparam int DEFAULT_MEMORY_DEPTH = 256;

    // Instruction opcodes
    typedef enum logic [OP_W-1:0] {
        OP_DEC = 4'd0,
        OP_LDA = 4'd1,
        OP_LDB = 4'd2,
        OP_LDI = 4'd3,
        OP_ST  = 4'd4,
        OP_XCH = 4'd5,
        OP_ADD = 4'd6,
        OP_HLT = 4'd7,
        OP_JMP = 4'd8,
        OP_JZS = 4'd9,
        OP_JVS = 4'd10
    } t_opcode;

endpackage

@@ design/ame_data_mem.sv @@
// Data memory: one write port, one read port, registered read data (read-first).
module ame_data_mem
    import ame_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MEMORY_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/accumulator_machine_execute_core.sv @@
// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+----------------------------------------------
// in        | input     | i_valid / o_ready  | operation, operand_address, symbol_found, imm
// out       | output    | o_valid / i_ready  | pc, register A/B, overflow, zero, halted
//
// One instruction per cycle sustained while the output is not stalled; a result is registered
// in the output register when its instruction leaves the execute stage, then offered on o_valid.
// The operand read is issued to the data memory on accept; the instruction executes in the
// execute stage on the read data, a write from the previous instruction being forwarded.
// Reset (synchronous, active low) clears registers, flags, counter and pipeline valids;
// data memory content is not cleared. A stalled output holds execute and then input.
`include "accumulator_machine_execute_core_assert.svh"

module accumulator_machine_execute_core
    import ame_pkg::*;
#(
    parameter int MEMORY_DEPTH = DEFAULT_MEMORY_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [ADDR_IN_W-1:0] i_operand_address,
    input  logic                 i_symbol_found,
    input  logic signed [WORD_W-1:0] i_immediate,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ADDR_IN_W-1:0] o_program_counter,
    output logic signed [WORD_W-1:0] o_register_a,
    output logic signed [WORD_W-1:0] o_register_b,
    output logic                 o_overflow_flag,
    output logic                 o_zero_flag,
    output logic                 o_halted
);

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int PW = (AW > ADDR_IN_W) ? AW : ADDR_IN_W;

    // Operand address modulo depth, worked out at elaboration
    logic [AW-1:0] w_wrap_tab [ADDR_SPAN];
    for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_wrap
        assign w_wrap_tab[g] = AW'(g % MEMORY_DEPTH);
    end

    // Architectural state
    logic [WORD_W-1:0] r_acc_a, r_acc_b, n_acc_a, n_acc_b;
    logic              r_ovf, r_zero, r_halt, n_ovf, n_zero, n_halt;
    logic [AW-1:0]     r_pc, n_pc;

    // Execute stage
    logic              r_s2_valid;
    t_opcode           r_s2_op;
    logic [AW-1:0]     r_s2_addr;
    logic              r_s2_found;
    logic [WORD_W-1:0] r_s2_imm;

    // Forwarding of a write that landed on the same edge as the operand read
    logic              r_fwd_hit;
    logic [WORD_W-1:0] r_fwd_data;

    // Output register
    logic                 r_out_valid;
    logic [ADDR_IN_W-1:0] r_out_pc;
    logic [WORD_W-1:0]    r_out_a, r_out_b;
    logic                 r_out_ovf, r_out_zero, r_out_halt;

    logic              w_accept, w_s2_fire;
    logic [AW-1:0]     w_rd_addr, w_pc_inc;
    logic              w_wr_en, n_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [WORD_W-1:0] w_wr_data, w_mem_q, w_operand;
    logic [WORD_W:0]   w_sum;
    logic              w_sum_ovf;
    logic [PW-1:0]     w_pc_ext;

    // Handshake
    assign w_s2_fire = r_s2_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s2_valid || w_s2_fire;
    assign w_accept  = i_valid && o_ready;
    assign w_rd_addr = w_wrap_tab[i_operand_address];

    ame_data_mem #(
        .DEPTH (MEMORY_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_mem_q)
    );

    assign w_operand = r_fwd_hit ? r_fwd_data : w_mem_q;
    assign w_pc_inc  = (r_pc == AW'(MEMORY_DEPTH - 1)) ? '0 : r_pc + AW'(1);
    assign w_sum     = {r_acc_a[WORD_W-1], r_acc_a} + {r_acc_b[WORD_W-1], r_acc_b};
    assign w_sum_ovf = w_sum[WORD_W] ^ w_sum[WORD_W-1];

    // Instruction execute
    always_comb begin
        n_acc_a   = r_acc_a;
        n_acc_b   = r_acc_b;
        n_ovf     = r_ovf;
        n_zero    = r_zero;
        n_halt    = r_halt;
        n_pc      = r_pc;
        n_wr_en   = 1'b0;
        w_wr_addr = r_s2_addr;
        w_wr_data = r_acc_a;
        if (!r_halt) begin
            case (r_s2_op)
                OP_DEC: begin
                    n_wr_en   = 1'b1;
                    w_wr_addr = r_pc;
                    w_wr_data = '0;
                    n_pc      = w_pc_inc;
                end
                OP_LDA: begin
                    if (r_s2_found) n_acc_a = w_operand;
                    n_pc = w_pc_inc;
                end
                OP_LDB: begin
                    if (r_s2_found) n_acc_b = w_operand;
                    n_pc = w_pc_inc;
                end
                OP_LDI: begin
                    n_acc_a = r_s2_imm;
                    n_pc    = w_pc_inc;
                end
                OP_ST: begin
                    if (r_s2_found) begin
                        n_wr_en = 1'b1;
                        n_pc    = w_pc_inc;
                    end else begin
                        n_halt = 1'b1;
                    end
                end
                OP_XCH: begin
                    n_acc_a = r_acc_b;
                    n_acc_b = r_acc_a;
                    n_pc    = w_pc_inc;
                end
                OP_ADD: begin
                    if (w_sum_ovf) n_ovf = 1'b1;
                    else n_zero = (w_sum[WORD_W-1:0] == '0);
                    n_acc_a = w_sum[WORD_W-1:0];
                    n_pc    = w_pc_inc;
                end
                OP_HLT: n_halt = 1'b1;
                OP_JMP: n_pc = r_s2_addr;
                OP_JZS: n_pc = r_zero ? r_s2_addr : w_pc_inc;
                OP_JVS: n_pc = r_ovf ? r_s2_addr : w_pc_inc;
                default: ;
            endcase
        end
    end

    assign w_wr_en  = w_s2_fire && n_wr_en;
    assign w_pc_ext = PW'(n_pc);

    // State, pipeline valids and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_a     <= '0;
            r_acc_b     <= '0;
            r_ovf       <= 1'b0;
            r_zero      <= 1'b0;
            r_halt      <= 1'b0;
            r_pc        <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (w_s2_fire) begin
                r_acc_a <= n_acc_a;
                r_acc_b <= n_acc_b;
                r_ovf   <= n_ovf;
                r_zero  <= n_zero;
                r_halt  <= n_halt;
                r_pc    <= n_pc;
            end
            if (o_ready) r_s2_valid <= i_valid;
            if (w_s2_fire) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (w_accept) r_fwd_hit <= w_wr_en && (w_wr_addr == w_rd_addr);
        end
    end

    // Execute stage payload and forwarded data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s2_op    <= t_opcode'(i_operation);
            r_s2_addr  <= w_rd_addr;
            r_s2_found <= i_symbol_found;
            r_s2_imm   <= i_immediate;
            r_fwd_data <= w_wr_data;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (w_s2_fire) begin
            r_out_pc   <= w_pc_ext[ADDR_IN_W-1:0];
            r_out_a    <= n_acc_a;
            r_out_b    <= n_acc_b;
            r_out_ovf  <= n_ovf;
            r_out_zero <= n_zero;
            r_out_halt <= n_halt;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_program_counter = r_out_pc;
    assign o_register_a      = r_out_a;
    assign o_register_b      = r_out_b;
    assign o_overflow_flag   = r_out_ovf;
    assign o_zero_flag       = r_out_zero;
    assign o_halted          = r_out_halt;

    // Checks
    `AME_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_halt |=> r_halt)
    `AME_ASSERT(a_ovf_sticky, i_clk, i_rst_n, r_ovf |=> r_ovf)
    `AME_ASSERT(a_no_write_halted, i_clk, i_rst_n, r_halt |-> !w_wr_en)
    `AME_ASSERT_ALWAYS(a_pc_in_range, i_clk, !i_rst_n || (r_pc <= AW'(MEMORY_DEPTH - 1)))

endmodule
